// ----- rtl/smma_pkg.sv -----
package smma_pkg;

	localparam int MAX_SIZE  = 8;
	localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
	localparam int AW        = $clog2(DEPTH);
	localparam int IW        = $clog2(MAX_SIZE);
	localparam int SW        = 4;
	localparam int CW        = AW + 1;
	localparam int EW        = 16;
	localparam int RW        = 35;

	localparam logic [1:0] REG_MATRIX_SIZE    = 2'd0;
	localparam logic [1:0] REG_OPERATION_MODE = 2'd1;

	localparam logic MODE_SUM     = 1'b0;
	localparam logic MODE_PRODUCT = 1'b1;

	typedef struct packed {
		logic          valid;
		logic          first;
		logic          lastk;
		logic          last;
		logic          mode;
		logic [IW-1:0] row;
		logic [IW-1:0] col;
		logic [AW-1:0] a_addr;
		logic [AW-1:0] b_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
	} cmd_t;

	typedef struct packed {
		logic stall;
		logic busy;
	} sts_t;

	function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] size);
		logic [SW-1:0] n;
		if (size == '0)
			n = SW'(1);
		else if (size > SW'(MAX_SIZE))
			n = SW'(MAX_SIZE);
		else
			n = size;
		return n;
	endfunction

endpackage

// ----- rtl/smma_datapath.sv -----
module smma_datapath
	import smma_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [2*EW-1:0]       in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RW-1:0]         out_value,
	output logic [IW-1:0]         out_row,
	output logic [IW-1:0]         out_col,
	output logic                  out_last
);

	logic [EW-1:0] mem_a [DEPTH];
	logic [EW-1:0] mem_b [DEPTH];

	logic                 v_s1, first_s1, lastk_s1, last_s1, mode_s1;
	logic [IW-1:0]        row_s1, col_s1;
	logic signed [EW-1:0] ra_s1, rb_s1;

	logic                 v_s2, first_s2, lastk_s2, last_s2;
	logic [IW-1:0]        row_s2, col_s2;
	logic [RW-1:0]        p_s2;

	logic [RW-1:0]        acc_q;
	logic                 out_valid_q;
	logic [RW-1:0]        out_value_q;
	logic [IW-1:0]        out_row_q, out_col_q;
	logic                 out_last_q;

	logic                 stall, emit;
	logic signed [2*EW-1:0] prod;
	logic signed [EW:0]     sum;
	logic [RW-1:0]        acc_next;

	assign emit  = v_s2 && lastk_s2;
	assign stall = emit && out_valid_q && !out_ready;
	assign sts.stall = stall;
	assign sts.busy  = v_s1 || v_s2;

	assign prod = ra_s1 * rb_s1;
	assign sum  = {ra_s1[EW-1], ra_s1} + {rb_s1[EW-1], rb_s1};
	assign acc_next = (first_s2 ? '0 : acc_q) + p_s2;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_a[cmd.wr_addr] <= in_data[EW-1:0];
			mem_b[cmd.wr_addr] <= in_data[2*EW-1:EW];
		end
		if (!stall) begin
			ra_s1 <= mem_a[cmd.a_addr];
			rb_s1 <= mem_b[cmd.b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!stall) begin
				v_s1 <= cmd.valid;
				v_s2 <= v_s1;
			end
			if (emit && !stall)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			first_s1 <= cmd.first;
			lastk_s1 <= cmd.lastk;
			last_s1  <= cmd.last;
			mode_s1  <= cmd.mode;
			row_s1   <= cmd.row;
			col_s1   <= cmd.col;

			first_s2 <= first_s1;
			lastk_s2 <= lastk_s1;
			last_s2  <= last_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			if (mode_s1 == MODE_PRODUCT)
				p_s2 <= {{(RW-2*EW){prod[2*EW-1]}}, prod};
			else
				p_s2 <= {{(RW-EW-9){sum[EW]}}, sum, 8'b0};

			if (v_s2)
				acc_q <= acc_next;
			if (emit) begin
				out_value_q <= acc_next;
				out_row_q   <= row_s2;
				out_col_q   <= col_s2;
				out_last_q  <= last_s2;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_last  = out_last_q;

endmodule

// ----- rtl/smma_ctrl.sv -----
module smma_ctrl
	import smma_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	output cmd_t       cmd,
	input  sts_t       sts
);

	typedef enum logic [1:0] {
		LOAD,
		RUN,
		DRAIN
	} state_t;

	state_t        state_q;
	logic [SW-1:0] size_q;
	logic          mode_q;
	logic          run_mode_q;
	logic [CW-1:0] load_cnt_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [AW-1:0] row_base_q;
	logic [AW-1:0] b_col_q;

	logic [SW-1:0] n;
	logic [IW-1:0] n_m1;
	logic [CW-1:0] total;
	logic          lastk, last_col, last_elem, accept;
	logic [AW-1:0] pos;

	assign n        = eff_size(size_q);
	assign n_m1     = IW'(n - SW'(1));
	assign total    = CW'(n) * CW'(n);
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == LOAD) && !cfg_valid;

	assign lastk     = (run_mode_q == MODE_SUM) || (k_q == n_m1);
	assign last_col  = (j_q == n_m1);
	assign last_elem = lastk && last_col && (i_q == n_m1);
	assign pos       = row_base_q + AW'(j_q);

	always_comb begin
		cmd.valid   = (state_q == RUN);
		cmd.first   = (k_q == '0);
		cmd.lastk   = lastk;
		cmd.last    = last_elem;
		cmd.mode    = run_mode_q;
		cmd.row     = i_q;
		cmd.col     = j_q;
		cmd.a_addr  = (run_mode_q == MODE_PRODUCT) ? row_base_q + AW'(k_q) : pos;
		cmd.b_addr  = (run_mode_q == MODE_PRODUCT) ? b_col_q : pos;
		cmd.wr_en   = accept;
		cmd.wr_addr = load_cnt_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= LOAD;
			size_q     <= SW'(4);
			mode_q     <= MODE_SUM;
			run_mode_q <= MODE_SUM;
			load_cnt_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			row_base_q <= '0;
			b_col_q    <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_MATRIX_SIZE) begin
					size_q     <= cfg_data;
					load_cnt_q <= '0;
				end else if (cfg_index == REG_OPERATION_MODE) begin
					mode_q     <= cfg_data[0];
					load_cnt_q <= '0;
				end
			end
			case (state_q)
				LOAD: begin
					if (accept) begin
						if (load_cnt_q + CW'(1) >= total) begin
							load_cnt_q <= '0;
							run_mode_q <= mode_q;
							i_q        <= '0;
							j_q        <= '0;
							k_q        <= '0;
							row_base_q <= '0;
							b_col_q    <= '0;
							state_q    <= RUN;
						end else begin
							load_cnt_q <= load_cnt_q + CW'(1);
						end
					end
				end
				RUN: begin
					if (!sts.stall) begin
						if (!lastk) begin
							k_q     <= k_q + IW'(1);
							b_col_q <= b_col_q + AW'(n);
						end else begin
							k_q <= '0;
							if (last_col) begin
								j_q        <= '0;
								i_q        <= i_q + IW'(1);
								row_base_q <= row_base_q + AW'(n);
								b_col_q    <= '0;
							end else begin
								j_q     <= j_q + IW'(1);
								b_col_q <= AW'(j_q) + AW'(1);
							end
						end
						if (last_elem)
							state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (!sts.busy)
						state_q <= LOAD;
				end
				default: state_q <= LOAD;
			endcase
		end
	end

endmodule

// ----- rtl/square_matrix_multiply_add.sv -----
// Square matrix sum / product engine, signed Q8.8 in, signed Q19.16 out.
// Input stream: n*n words in row-major order, each word one A and one B element.
// Config channel: index 0 = matrix_size (0 acts as 1, above 8 acts as 8),
// index 1 = operation_mode (0 sum, 1 product). Any write to either clears a
// partial load. Write only while the block is idle; s_tready drops while a
// write is offered.
// Loading takes one word per cycle. The word completing the load starts the
// compute phase, during which s_tready is low. Results leave in row-major order
// with tlast on the final element.
// Sum mode: one result per cycle while m_tready stays high.
// Product mode: each result is accumulated by the single multiply-accumulate
// walking k over the A row and B column.
// Once the last result is in the output register, loading resumes at the next clock edge.
// The output register holds a result while m_tready is low; when the next result
// reaches it, the pipeline and address sequencer freeze until it drains, so nothing is lost.
// Reset: matrix_size = 4, operation_mode = 0, load count cleared, no result held.
// Matrix stores are not cleared; only entries of the current load are read.
module square_matrix_multiply_add
	import smma_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // a_value[15:0], b_value[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // result_value[34:0], result_row[37:35], result_col[40:38]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	cmd_t          cmd;
	sts_t          sts;
	logic [RW-1:0] value;
	logic [IW-1:0] row, col;

	assign cfg_ready = 1'b1;

	smma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	smma_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (value),
		.out_row   (row),
		.out_col   (col),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'b0, col, row, value};

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import smma_pkg::*;

	localparam int             CLK_PERIOD    = 10;
	localparam int             RESET_CYCLES  = 9;
	localparam int             CYCLE_LIMIT   = 500000;
	localparam int             HOLD_CYCLES   = 300;
	localparam int             SETTLE_CYCLES = 16;
	localparam int             RANDOM_WORDS  = 70;
	localparam logic [1:0]     REG_NONE      = 2'd2;
	localparam logic [EW-1:0]  ELEM_MIN      = 16'h8000;
	localparam logic [EW-1:0]  ELEM_MAX      = 16'h7FFF;

	typedef struct {
		logic [RW-1:0] value;
		logic [IW-1:0] row;
		logic [IW-1:0] col;
		logic          last;
	} elem_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [3:0]  cfg_data = '0;

	logic [31:0] pending_words[$];
	elem_t       expected_elems[$];
	logic        word_taken = 1'b0;
	int          send_idle = 6;
	int          recv_idle = 50;
	int          hold_req = 0;
	int          hold_ack = 0;
	int          hold_left = 0;
	int          cycle_cnt = 0;
	int          err_cnt = 0;
	int          words_queued = 0;
	int          words_loaded = 0;
	int          elems_checked = 0;
	int          sum_loads = 0;
	int          product_loads = 0;
	int          reg_writes = 0;
	int          loads_dropped = 0;

	logic [SW-1:0]        size_reg = SW'(4);
	logic                 mode_reg = MODE_SUM;
	int                   fill_cnt = 0;
	logic signed [EW-1:0] mat_a[DEPTH];
	logic signed [EW-1:0] mat_b[DEPTH];

	square_matrix_multiply_add i_dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int side_of(input logic [SW-1:0] sz);
		if (sz == '0)
			return 1;
		if (sz > SW'(MAX_SIZE))
			return MAX_SIZE;
		return int'(sz);
	endfunction

	function automatic logic [EW-1:0] rand_elem();
		case ($urandom_range(7))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			default: return EW'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [RW-1:0] got,
			input logic [RW-1:0] want);
		$display("Mismatch at element %0d, %s: got %h, expected %h",
			elems_checked, what, got, want);
		err_cnt++;
	endtask

	task automatic apply_register(input logic [1:0] idx, input logic [3:0] val);
		reg_writes++;
		if (idx == REG_MATRIX_SIZE || idx == REG_OPERATION_MODE) begin
			if (fill_cnt != 0)
				loads_dropped++;
			fill_cnt = 0;
			if (idx == REG_MATRIX_SIZE)
				size_reg = val;
			else
				mode_reg = val[0];
		end
	endtask

	task automatic load_element(input logic [EW-1:0] a, input logic [EW-1:0] b);
		int n;
		int total;
		int i;
		int j;
		int k;
		longint acc;
		elem_t e;
		n = side_of(size_reg);
		total = n * n;
		words_loaded++;
		if (fill_cnt >= total)
			fill_cnt = 0;
		mat_a[fill_cnt] = a;
		mat_b[fill_cnt] = b;
		fill_cnt++;
		if (fill_cnt < total)
			return;
		fill_cnt = 0;
		if (mode_reg == MODE_SUM)
			sum_loads++;
		else
			product_loads++;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				if (mode_reg == MODE_SUM) begin
					acc = (longint'(mat_a[i * n + j]) + longint'(mat_b[i * n + j])) * 256;
				end else begin
					acc = 0;
					for (k = 0; k < n; k++)
						acc += longint'(mat_a[i * n + k]) * longint'(mat_b[k * n + j]);
				end
				e.value = RW'(acc);
				e.row = IW'(i);
				e.col = IW'(j);
				e.last = (i == n - 1) && (j == n - 1);
				expected_elems.push_back(e);
			end
		end
	endtask

	task automatic check_element();
		elem_t e;
		if (expected_elems.size() == 0) begin
			report_mismatch("element with none expected", m_tdata[RW-1:0], '0);
			return;
		end
		e = expected_elems.pop_front();
		if (m_tdata[RW-1:0] !== e.value)
			report_mismatch("value", m_tdata[RW-1:0], e.value);
		if (m_tdata[RW+IW-1:RW] !== e.row)
			report_mismatch("row", RW'(m_tdata[RW+IW-1:RW]), RW'(e.row));
		if (m_tdata[RW+2*IW-1:RW+IW] !== e.col)
			report_mismatch("col", RW'(m_tdata[RW+2*IW-1:RW+IW]), RW'(e.col));
		if (m_tlast !== e.last)
			report_mismatch("last", RW'(m_tlast), RW'(e.last));
		elems_checked++;
	endtask

	always @(posedge clk) begin
		word_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				load_element(s_tdata[EW-1:0], s_tdata[2*EW-1:EW]);
			if (m_tvalid && m_tready)
				check_element();
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Some tests failed");
			$finish;
		end
	end

	// hold the word until taken, then offer the next one or idle
	always @(negedge clk) begin
		if (!s_tvalid || word_taken) begin
			if (arst_n && pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
				s_tdata <= pending_words.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle;
		end
	end

	task automatic queue_word(input logic [EW-1:0] a, input logic [EW-1:0] b);
		pending_words.push_back({b, a});
		words_queued++;
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			queue_word(rand_elem(), rand_elem());
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain all words and results, then let the block go idle
	task automatic settle();
		while (pending_words.size() != 0 || s_tvalid || expected_elems.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_pace();
		if (words_queued < 60) begin
			send_idle = 6;
			recv_idle = 50;
		end else if (words_queued < 120) begin
			send_idle = 50;
			recv_idle = 6;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	initial begin
		logic [SW-1:0] side_sel;
		int n;
		int start_cnt;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_pace();

		queue_word(ELEM_MIN, ELEM_MIN);
		queue_word(ELEM_MAX, ELEM_MAX);
		queue_word(ELEM_MIN, ELEM_MAX);
		queue_word(ELEM_MAX, ELEM_MIN);
		queue_word('0, '0);
		queue_word('1, EW'(1));
		queue_random(10);
		settle();

		write_reg(REG_MATRIX_SIZE, '0);
		write_reg(REG_OPERATION_MODE, {3'b000, MODE_PRODUCT});
		queue_word(ELEM_MIN, ELEM_MIN);
		settle();

		// drop a partial load with a register write
		write_reg(REG_MATRIX_SIZE, SW'(2));
		queue_word(ELEM_MAX, ELEM_MAX);
		settle();
		write_reg(REG_OPERATION_MODE, {3'b111, MODE_PRODUCT});
		queue_word(ELEM_MIN, ELEM_MAX);
		queue_word(ELEM_MAX, ELEM_MIN);
		queue_word(ELEM_MAX, ELEM_MIN);
		queue_word(ELEM_MIN, ELEM_MAX);
		settle();

		// unused index keeps the partial load
		queue_random(1);
		settle();
		write_reg(REG_NONE, 4'hF);
		queue_random(3);
		settle();

		start_cnt = words_queued;
		while (words_queued - start_cnt < RANDOM_WORDS) begin
			set_pace();
			n = side_of(size_reg);
			if (n > 1 && $urandom_range(3) == 0) begin
				queue_random($urandom_range(n * n - 1, 1));
				settle();
			end
			case ($urandom_range(9))
				0: side_sel = '0;
				1: side_sel = SW'($urandom_range(15, MAX_SIZE + 1));
				2: side_sel = SW'(MAX_SIZE);
				default: side_sel = SW'($urandom_range(5, 1));
			endcase
			write_reg(REG_MATRIX_SIZE, side_sel);
			write_reg(REG_OPERATION_MODE, 4'($urandom_range(15)));
			n = side_of(side_sel);
			repeat (n > 5 ? 1 : $urandom_range(3, 1))
				queue_random(n * n);
			settle();
		end

		// stall the output long enough to back up the input
		set_pace();
		write_reg(REG_MATRIX_SIZE, SW'(3));
		write_reg(REG_OPERATION_MODE, {3'b000, MODE_PRODUCT});
		hold_req++;
		queue_random(27);
		settle();

		set_pace();
		write_reg(REG_MATRIX_SIZE, SW'(MAX_SIZE));
		repeat (DEPTH)
			queue_word(ELEM_MIN, ELEM_MIN);
		repeat (DEPTH)
			queue_word(ELEM_MIN, ELEM_MAX);
		settle();

		$display("Loaded %0d words into %0d sum and %0d product matrices, %0d elements checked.",
			words_loaded, sum_loads, product_loads, elems_checked);
		$display("Size settings 0 to 5 and 8 to 15, %0d register writes, %0d partial loads dropped, one long stall.",
			reg_writes, loads_dropped);
		if (err_cnt == 0 && expected_elems.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
